@@ src/lcdser_pkg.sv @@
// Shared types and constants for the 9-bit serial display link transmitter.
package lcdser_pkg;

	// Item kinds as they arrive on the input channel.
	typedef enum logic [1:0] {
		KIND_CMD    = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_PIXELS = 2'd2,
		KIND_DESEL  = 2'd3
	} kind_t;

	// Command/data flag sent as the first frame bit.
	localparam logic FLAG_CMD  = 1'b0;
	localparam logic FLAG_DATA = 1'b1;

	// A frame is the flag bit followed by eight data bits, two pin states per bit.
	localparam int FRAME_BITS   = 9;
	localparam int FRAME_STATES = 2 * FRAME_BITS;
	localparam int STEP_W       = $clog2(FRAME_STATES);
	localparam int BIT_IDX_W    = $clog2(FRAME_BITS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAME_STATES - 1);

	// Remaining pixel frames after the first one has been queued.
	localparam int PEND_W = 2;
	localparam logic [PEND_W-1:0] PIXEL_FRAMES_LEFT = 2'd2;

	// Frame queue between the front and back parts.
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	// One unit of work for the serializer: a 9-bit frame or a deselect state.
	typedef struct packed {
		logic       desel;
		logic       flag;
		logic [7:0] data;
		logic       last;
	} frame_t;

endpackage

@@ src/lcdser_in_if.sv @@
// Input channel carrying one transmit request per item.
interface lcdser_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  byte_value;
	logic [11:0] pixel_first;
	logic [11:0] pixel_second;

	modport source (output valid, kind, byte_value, pixel_first, pixel_second, input ready);
	modport sink (input valid, kind, byte_value, pixel_first, pixel_second, output ready);
endinterface

@@ src/lcdser_out_if.sv @@
// Output channel carrying one pin state per item.
interface lcdser_out_if;
	logic valid;
	logic ready;
	logic reset_pin;
	logic chip_enable_pin;
	logic serial_data_pin;
	logic serial_clock_pin;
	logic last;

	modport source (output valid, reset_pin, chip_enable_pin, serial_data_pin,
		serial_clock_pin, last, input ready);
	modport sink (input valid, reset_pin, chip_enable_pin, serial_data_pin,
		serial_clock_pin, last, output ready);
endinterface

@@ src/lcd_9bit_serial_transmitter_top.sv @@
// With the serializer idle, the first pin state of a request is written into the frame queue
// at the edge that accepts it and from there into the output register.
// The serializer gives one pin state per cycle while the output is taken, so a command or
// data byte is 18 pin states, a pixel pair 54 and a deselect 1. Requests are accepted while
// earlier ones serialize, as long as the frame queue has room and no pixel frames wait.
// Reset empties the frame queue, clears the serializer and drops the output valid.
module lcd_9bit_serial_transmitter_top (
	input  logic          clk,
	input  logic          arst_n,
	lcdser_in_if.sink     item,
	lcdser_out_if.source  pins
);
	import lcdser_pkg::*;

	logic   push_valid;
	logic   push_ready;
	frame_t push_frame;
	logic   q_valid;
	logic   q_pop;
	frame_t q_frame;

	// Request intake and frame split.
	lcdser_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_frame (push_frame)
	);

	// Frame queue.
	lcdser_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_frame (push_frame),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_frame  (q_frame)
	);

	// Pin state serializer.
	lcdser_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_frame (q_frame),
		.pins    (pins)
	);
endmodule

@@ src/lcdser_front.sv @@
// Front part: accepts requests and splits them into frames for the queue.
module lcdser_front (
	input  logic                clk,
	input  logic                arst_n,
	lcdser_in_if.sink           item,
	output logic                push_valid,
	input  logic                push_ready,
	output lcdser_pkg::frame_t  push_frame
);
	import lcdser_pkg::*;

	logic [PEND_W-1:0] pend_cnt_q;
	logic [7:0]        pend_b1_q;
	logic [7:0]        pend_b2_q;
	logic              accept;

	// New requests are taken only when no pixel frames are still waiting.
	assign item.ready = (pend_cnt_q == '0) && push_ready;
	assign accept     = item.valid && item.ready;

	// Frame offered to the queue: a waiting pixel byte first, else the new request.
	always_comb begin
		push_frame = '0;
		if (pend_cnt_q != '0) begin
			push_valid       = 1'b1;
			push_frame.flag  = FLAG_DATA;
			push_frame.data  = pend_b1_q;
			push_frame.last  = (pend_cnt_q == PEND_W'(1));
		end else begin
			push_valid = item.valid;
			unique case (kind_t'(item.kind))
				KIND_CMD: begin
					push_frame.flag = FLAG_CMD;
					push_frame.data = item.byte_value;
					push_frame.last = 1'b1;
				end
				KIND_DATA: begin
					push_frame.flag = FLAG_DATA;
					push_frame.data = item.byte_value;
					push_frame.last = 1'b1;
				end
				KIND_PIXELS: begin
					push_frame.flag = FLAG_DATA;
					push_frame.data = item.pixel_first[11:4];
				end
				KIND_DESEL: begin
					push_frame.desel = 1'b1;
					push_frame.last  = 1'b1;
				end
				default: begin
					push_frame.desel = 1'b1;
					push_frame.last  = 1'b1;
				end
			endcase
		end
	end

	// Count of pixel frames still to queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= '0;
		end else if (pend_cnt_q != '0) begin
			if (push_ready) begin
				pend_cnt_q <= pend_cnt_q - PEND_W'(1);
			end
		end else if (accept && (kind_t'(item.kind) == KIND_PIXELS)) begin
			pend_cnt_q <= PIXEL_FRAMES_LEFT;
		end
	end

	// Second and third pixel bytes, shifted forward as each one is queued.
	always_ff @(posedge clk) begin
		if (pend_cnt_q != '0) begin
			if (push_ready) begin
				pend_b1_q <= pend_b2_q;
			end
		end else if (accept) begin
			pend_b1_q <= {item.pixel_first[3:0], item.pixel_second[11:8]};
			pend_b2_q <= item.pixel_second[7:0];
		end
	end

	// While pixel frames wait, no new request may be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pend_cnt_q != '0) |-> !item.ready)
		else $error("request accepted while pixel frames are pending");

	// A pixel request always leaves exactly two frames pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (kind_t'(item.kind) == KIND_PIXELS)) |=> (pend_cnt_q == PIXEL_FRAMES_LEFT))
		else $error("pixel request did not schedule its remaining frames");
endmodule

@@ src/lcdser_queue.sv @@
// Short frame queue between the front and back parts.
module lcdser_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  lcdser_pkg::frame_t  push_frame,
	output logic                pop_valid,
	input  logic                pop,
	output lcdser_pkg::frame_t  pop_frame
);
	import lcdser_pkg::*;

	frame_t              slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_frame  = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QUEUE_AW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QUEUE_AW + 1)'(1);
			end
		end
	end

	// Frame storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_frame;
		end
	end

	// The fill count never passes the depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
		else $error("frame queue overflow");

	// The count follows the pointer difference.
	assert property (@(posedge clk) disable iff (!arst_n)
		QUEUE_AW'(wr_ptr_q - rd_ptr_q) == count_q[QUEUE_AW-1:0])
		else $error("frame queue pointers disagree with count");
endmodule

@@ src/lcdser_back.sv @@
// Back part: serializes queued frames into one pin state per cycle while the output is taken.
module lcdser_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  lcdser_pkg::frame_t  q_frame,
	lcdser_out_if.source        pins
);
	import lcdser_pkg::*;

	logic                 active_q;
	frame_t               frame_q;
	logic [STEP_W-1:0]    step_q;
	logic                 out_valid_q;
	logic                 ce_q;
	logic                 sd_q;
	logic                 sck_q;
	logic                 last_q;

	logic                 adv;
	logic                 have_frame;
	frame_t               cur;
	logic [STEP_W-1:0]    cur_step;
	logic [FRAME_BITS-1:0] word;
	logic [BIT_IDX_W-1:0] bit_idx;
	logic                 frame_end;

	// The output register advances when empty or when its state is taken.
	assign adv        = !out_valid_q || pins.ready;
	assign have_frame = active_q || q_valid;
	assign cur        = active_q ? frame_q : q_frame;
	assign cur_step   = active_q ? step_q : '0;
	assign q_pop      = adv && !active_q && q_valid;

	// Select the frame bit for this step; two steps per bit, MSB first.
	assign word      = {cur.flag, cur.data};
	assign bit_idx   = BIT_IDX_W'(FRAME_BITS - 1) - BIT_IDX_W'(cur_step[STEP_W-1:1]);
	assign frame_end = cur.desel || (cur_step == LAST_STEP);

	// Serializer progress through the current frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= have_frame;
			if (have_frame) begin
				active_q <= !frame_end;
			end
		end
	end

	// Frame copy, step count and output pin state.
	always_ff @(posedge clk) begin
		if (adv && have_frame) begin
			frame_q <= cur;
			step_q  <= cur_step + STEP_W'(1);
			if (cur.desel) begin
				ce_q  <= 1'b1;
				sd_q  <= 1'b0;
				sck_q <= 1'b1;
				last_q <= cur.last;
			end else begin
				ce_q  <= 1'b0;
				sd_q  <= word[bit_idx];
				sck_q <= cur_step[0];
				last_q <= cur.last && (cur_step == LAST_STEP);
			end
		end
	end

	assign pins.valid            = out_valid_q;
	assign pins.reset_pin        = 1'b1;
	assign pins.chip_enable_pin  = ce_q;
	assign pins.serial_data_pin  = sd_q;
	assign pins.serial_clock_pin = sck_q;
	assign pins.last             = last_q;

	// A deselect state always ends its request with the clock high.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ce_q) |-> (last_q && sck_q && !sd_q))
		else $error("deselect state malformed");

	// A frame only ends its request on a clock-high state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> sck_q)
		else $error("request ended on a clock-low state");
endmodule

@@ tb/sv/lcd_9bit_serial_transmitter_top_test.sv @@
// Self-checking testbench for the 9-bit serial display link transmitter.
module lcd_9bit_serial_transmitter_top_test;
	import lcdser_pkg::*;

	// One transmit request as the sender offers it.
	typedef struct {
		kind_t       kind;
		logic [7:0]  byte_value;
		logic [11:0] pixel_first;
		logic [11:0] pixel_second;
		logic        wait_drain;
	} request_t;

	// One pin state as seen on the output channel.
	typedef struct packed {
		logic reset_pin;
		logic chip_enable_pin;
		logic serial_data_pin;
		logic serial_clock_pin;
		logic last;
	} pin_state_t;

	localparam int LONG_HOLD_CYCLES = 400;
	localparam int LONG_HOLD_AFTER  = 1500;
	localparam int RANDOM_REQUESTS  = 280;
	localparam int TAIL_CYCLES      = 8;
	localparam int REPORT_LIMIT     = 10;

	logic clk = 1'b0;
	logic arst_n;

	lcdser_in_if  in_ch ();
	lcdser_out_if out_ch ();

	lcd_9bit_serial_transmitter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch.sink),
		.pins   (out_ch.source)
	);

	request_t   pending_requests[$];
	pin_state_t expected_pins[$];
	request_t   current_request;
	pin_state_t got_pins;
	pin_state_t want_pins;

	int  requests_accepted = 0;
	int  kind_count[4] = '{0, 0, 0, 0};
	int  pins_checked = 0;
	int  mismatches = 0;
	int  send_gap = 0;
	int  hold_left = 0;
	bit  long_hold_done = 1'b0;
	bit  drain_next = 1'b0;

	// Free-running clock, period of two time units.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		else if (roll < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Appends the eighteen pin states of one 9-bit frame, flag bit first.
	function automatic void push_frame_states(logic flag, logic [7:0] data, logic final_frame);
		logic [8:0] word;
		pin_state_t s;
		word = {flag, data};
		for (int b = FRAME_BITS - 1; b >= 0; b--) begin
			for (int ph = 0; ph < 2; ph++) begin
				s.reset_pin = 1'b1;
				s.chip_enable_pin = 1'b0;
				s.serial_data_pin = word[b];
				s.serial_clock_pin = (ph == 1);
				s.last = final_frame && (b == 0) && (ph == 1);
				expected_pins.push_back(s);
			end
		end
	endfunction

	// Works out the pin states that one accepted request must produce.
	function automatic void predict_pin_states(request_t r);
		pin_state_t s;
		case (r.kind)
			KIND_CMD: begin
				push_frame_states(FLAG_CMD, r.byte_value, 1'b1);
			end
			KIND_DATA: begin
				push_frame_states(FLAG_DATA, r.byte_value, 1'b1);
			end
			KIND_PIXELS: begin
				// Two RGB444 pixels are packed into three data bytes.
				push_frame_states(FLAG_DATA, r.pixel_first[11:4], 1'b0);
				push_frame_states(FLAG_DATA, {r.pixel_first[3:0], r.pixel_second[11:8]}, 1'b0);
				push_frame_states(FLAG_DATA, r.pixel_second[7:0], 1'b1);
			end
			default: begin
				s.reset_pin = 1'b1;
				s.chip_enable_pin = 1'b1;
				s.serial_data_pin = 1'b0;
				s.serial_clock_pin = 1'b1;
				s.last = 1'b1;
				expected_pins.push_back(s);
			end
		endcase
	endfunction

	// Queues a request; a pending drain mark goes onto it.
	function automatic void enqueue(kind_t k, logic [7:0] b, logic [11:0] p, logic [11:0] q);
		request_t r;
		r.kind = k;
		r.byte_value = b;
		r.pixel_first = p;
		r.pixel_second = q;
		r.wait_drain = drain_next;
		drain_next = 1'b0;
		pending_requests.push_back(r);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [11:0] rand_pixel();
		return 12'($urandom_range(4095));
	endfunction

	// Sender: offers queued requests, with random gaps outside a no-gap window.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.kind <= KIND_CMD;
			in_ch.byte_value <= 8'h00;
			in_ch.pixel_first <= 12'h000;
			in_ch.pixel_second <= 12'h000;
			send_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_pin_states(current_request);
				kind_count[current_request.kind]++;
				requests_accepted++;
				if ((requests_accepted % 100) >= 25)
					send_gap = pick_gap();
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_requests.size() == 0 ||
						(pending_requests[0].wait_drain && expected_pins.size() != 0)) begin
					in_ch.valid <= 1'b0;
				end else begin
					current_request = pending_requests.pop_front();
					in_ch.kind <= current_request.kind;
					in_ch.byte_value <= current_request.byte_value;
					in_ch.pixel_first <= current_request.pixel_first;
					in_ch.pixel_second <= current_request.pixel_second;
					in_ch.valid <= 1'b1;
				end
			end
		end
	end

	// Receiver: checks each pin state and stalls at random, once for a long stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got_pins.reset_pin = out_ch.reset_pin;
				got_pins.chip_enable_pin = out_ch.chip_enable_pin;
				got_pins.serial_data_pin = out_ch.serial_data_pin;
				got_pins.serial_clock_pin = out_ch.serial_clock_pin;
				got_pins.last = out_ch.last;
				if (expected_pins.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("Unexpected pin state %b with nothing outstanding", got_pins);
				end else begin
					want_pins = expected_pins.pop_front();
					if (got_pins.reset_pin !== want_pins.reset_pin ||
							got_pins.chip_enable_pin !== want_pins.chip_enable_pin ||
							got_pins.serial_data_pin !== want_pins.serial_data_pin ||
							got_pins.serial_clock_pin !== want_pins.serial_clock_pin ||
							got_pins.last !== want_pins.last) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"Pin state %0d mismatch (rst ce sda scl last):",
								" expected %b %b %b %b %b, got %b %b %b %b %b"},
								pins_checked, want_pins.reset_pin,
								want_pins.chip_enable_pin, want_pins.serial_data_pin,
								want_pins.serial_clock_pin, want_pins.last,
								got_pins.reset_pin, got_pins.chip_enable_pin,
								got_pins.serial_data_pin, got_pins.serial_clock_pin,
								got_pins.last);
					end
					pins_checked++;
				end
			end
			if (!long_hold_done && pins_checked >= LONG_HOLD_AFTER) begin
				hold_left = LONG_HOLD_CYCLES;
				long_hold_done = 1'b1;
			end else if (hold_left == 0 && (pins_checked % 3000) >= 800) begin
				hold_left = pick_gap();
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Builds the request list, applies reset and waits for the run to drain.
	initial begin
		int   random_count;
		int   payload;
		kind_t k;

		arst_n = 1'b0;

		// Directed requests: byte extremes, flag values, pixel packing corners, deselects.
		enqueue(KIND_CMD, 8'h00, 12'h000, 12'h000);
		enqueue(KIND_CMD, 8'hFF, 12'h000, 12'h000);
		enqueue(KIND_CMD, 8'h2C, 12'h000, 12'h000);
		enqueue(KIND_CMD, 8'h80, 12'hFFF, 12'hFFF);
		enqueue(KIND_DATA, 8'h00, 12'hFFF, 12'h000);
		enqueue(KIND_DATA, 8'hFF, 12'h000, 12'hFFF);
		enqueue(KIND_DATA, 8'h0F, 12'h000, 12'h000);
		enqueue(KIND_DATA, 8'hA5, 12'h000, 12'h000);
		enqueue(KIND_PIXELS, 8'hFF, 12'h000, 12'h000);
		enqueue(KIND_PIXELS, 8'h00, 12'hFFF, 12'hFFF);
		enqueue(KIND_PIXELS, 8'h00, 12'h800, 12'h001);
		enqueue(KIND_PIXELS, 8'h00, 12'h0F0, 12'hF0F);
		enqueue(KIND_PIXELS, 8'h00, 12'h123, 12'hABC);
		enqueue(KIND_DESEL, 8'h00, 12'h000, 12'h000);
		enqueue(KIND_DESEL, 8'hFF, 12'hFFF, 12'hFFF);
		enqueue(KIND_DESEL, 8'h5A, 12'h5A5, 12'hA5A);
		enqueue(KIND_CMD, 8'h2C, 12'h000, 12'h000);
		enqueue(KIND_PIXELS, 8'h00, 12'h5A5, 12'hA5A);
		enqueue(KIND_DESEL, 8'h00, 12'h000, 12'h000);

		// Random part: mostly well-formed write bursts, the rest single noise requests.
		random_count = 0;
		drain_next = 1'b1;
		while (random_count < RANDOM_REQUESTS) begin
			if (random_count >= RANDOM_REQUESTS / 2 && random_count < RANDOM_REQUESTS / 2 + 8)
				drain_next = 1'b1;
			if ($urandom_range(99) < 65) begin
				enqueue(KIND_CMD, $urandom_range(1) ? 8'h2C : rand_byte(),
					rand_pixel(), rand_pixel());
				payload = $urandom_range(1, 6);
				for (int i = 0; i < payload; i++) begin
					k = ($urandom_range(2) != 0) ? KIND_PIXELS : KIND_DATA;
					enqueue(k, rand_byte(), rand_pixel(), rand_pixel());
				end
				enqueue(KIND_DESEL, rand_byte(), rand_pixel(), rand_pixel());
				random_count += payload + 2;
			end else begin
				enqueue(kind_t'($urandom_range(3)), rand_byte(), rand_pixel(), rand_pixel());
				random_count++;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() > 0 || in_ch.valid)
			@(posedge clk);
		while (expected_pins.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d command, %0d data, %0d pixel pair, %0d deselect.",
			requests_accepted, kind_count[KIND_CMD], kind_count[KIND_DATA],
			kind_count[KIND_PIXELS], kind_count[KIND_DESEL]);
		$display("Checked %0d pin states with %0d mismatches, one long receiver stall.",
			pins_checked, mismatches);
		if (mismatches == 0 && expected_pins.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5000000;
		$display("Timeout with %0d pin states still outstanding", expected_pins.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
